// File: hw/rtl/shadowed_bitmap_block_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shadowed bitmap block allocator
// Each macro expands to a labeled concurrent assertion, or to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SHADOWED_BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define SHADOWED_BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SBBA_ASSERT_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("sbba: forbidden condition seen");
`define SBBA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sbba: implication failed");
`define SBBA_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sbba: next-cycle implication failed");
`else
`define SBBA_ASSERT_NEVER(lbl, ck, rs, cond)
`define SBBA_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define SBBA_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

// File: hw/rtl/sbba_pkg.sv
// ----------------------------------------------------------------------------
// sbba_pkg
// Shared constants, codes, types and bit-search helpers of the allocator.
// ----------------------------------------------------------------------------
package sbba_pkg;

  localparam int MAP_BYTES = 4096;
  localparam int ADDR_W    = $clog2(MAP_BYTES);
  localparam int SIZE_W    = 13;
  localparam int BLK_W     = 15;
  localparam int STEP_W    = 13;

  localparam logic [STEP_W-1:0] GROW_STEP_RESET = 13'd1000;

  localparam logic [2:0] REQ_OPEN  = 3'd0;
  localparam logic [2:0] REQ_LOAD  = 3'd1;
  localparam logic [2:0] REQ_ALLOC = 3'd2;
  localparam logic [2:0] REQ_FREE  = 3'd3;
  localparam logic [2:0] REQ_QUERY = 3'd4;
  localparam logic [2:0] REQ_LAST  = 3'd5;
  localparam logic [2:0] REQ_CLEAR = 3'd6;
  localparam logic [2:0] REQ_READ  = 3'd7;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [BLK_W-1:0]  block_id;
    logic [11:0]       byte_index;
    logic [7:0]        byte_value;
    logic [SIZE_W-1:0] open_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [BLK_W-1:0]  block_out;
    logic              free_now;
    logic              free_at_start;
    logic              map_empty;
    logic [7:0]        read_value;
    logic [SIZE_W-1:0] size_bytes;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_cmd_t;

  // lowest clear bit; 7 when all bits are set
  function automatic logic [2:0] lowest_zero(input logic [7:0] x);
    logic [2:0] r;
    r = 3'd7;
    for (int k = 7; k >= 0; k--) begin
      if (!x[k]) r = 3'(k);
    end
    return r;
  endfunction

  // highest set bit; 0 when no bit is set
  function automatic logic [2:0] highest_one(input logic [7:0] x);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (x[k]) r = 3'(k);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/sbba_req_if.sv
// ----------------------------------------------------------------------------
// sbba_req_if
// Request channel: valid/ready handshake with one request per beat.
// ----------------------------------------------------------------------------
interface sbba_req_if import sbba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [BLK_W-1:0]  block_id;
  logic [11:0]       byte_index;
  logic [7:0]        byte_value;
  logic [SIZE_W-1:0] open_bytes;

  modport source (
    output valid, req_type, block_id, byte_index, byte_value, open_bytes,
    input  ready
  );
  modport sink (
    input  valid, req_type, block_id, byte_index, byte_value, open_bytes,
    output ready
  );
endinterface

// File: hw/rtl/sbba_rsp_if.sv
// ----------------------------------------------------------------------------
// sbba_rsp_if
// Result channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface sbba_rsp_if import sbba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [BLK_W-1:0]  block_out;
  logic              free_now;
  logic              free_at_start;
  logic              map_empty;
  logic [7:0]        read_value;
  logic [SIZE_W-1:0] size_bytes;

  modport source (
    output valid, status, block_out, free_now, free_at_start, map_empty,
           read_value, size_bytes,
    input  ready
  );
  modport sink (
    input  valid, status, block_out, free_now, free_at_start, map_empty,
           read_value, size_bytes,
    output ready
  );
endinterface

// File: hw/rtl/shadowed_bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// shadowed_bitmap_block_allocator_top
// Block allocator over a snapshot map and a current map, with APB config.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request beats (open, load, allocate, free, query, last block,
//          clear current, read byte); taken when valid and ready are high.
//   rsp  : exactly one result beat per request, in request order.
//   APB  : one register, grow_step_bytes, at address 0 (reset 1000). Write
//          it only while no request is in flight.
// Request flow, from the request beat to the result beat:
//   load and out-of-range requests go straight to the result; free, query
//   and read first read the maps. Allocate reads and checks each map byte
//   scanned from the hint, and zeroes the new bytes when the size in use
//   grows. Last block reads and checks each byte walked down from the size
//   in use. Open and clear current sweep one byte per cycle over the size
//   in use.
// One request is processed at a time; the next is taken once the result
//   has moved to the output register, so a stalled receiver leaves one
//   result in the output register and one in the sequencer, then intake stops.
// Reset clears the size in use and the hint; map bytes at or above the
//   size in use are never read before being zeroed, so no clearing pass
//   runs after reset and the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`include "shadowed_bitmap_block_allocator_top_defines.svh"

module shadowed_bitmap_block_allocator_top import sbba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sbba_req_if.sink    req,
  sbba_rsp_if.source  rsp
);

  logic [STEP_W-1:0] grow_step;
  logic              cfg_wr;
  logic              req_fire;
  req_t              req_in;
  mem_cmd_t          cur_cmd;
  mem_cmd_t          st_cmd;
  logic [7:0]        cur_rd;
  logic [7:0]        st_rd;
  logic              res_valid;
  rsp_t              res;
  logic              res_take;
  logic              ctrl_ready;

  // config register: single word at address 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == 2'b00);
  assign prdata = {{(32-STEP_W){1'b0}}, grow_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      grow_step <= GROW_STEP_RESET;
    end else if (cfg_wr) begin
      grow_step <= pwdata[STEP_W-1:0];
    end
  end

  // request intake
  assign req.ready = ctrl_ready;
  assign req_fire  = req.valid && ctrl_ready;
  assign req_in    = '{req_type: req.req_type, block_id: req.block_id,
                       byte_index: req.byte_index, byte_value: req.byte_value,
                       open_bytes: req.open_bytes};

  sbba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_fire  (req_fire),
    .req_in    (req_in),
    .step_cfg  (grow_step),
    .ready     (ctrl_ready),
    .cur_cmd   (cur_cmd),
    .st_cmd    (st_cmd),
    .cur_rd    (cur_rd),
    .st_rd     (st_rd),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // current map and start-of-transaction snapshot
  sbba_mem u_cur_map (
    .clk   (clk),
    .cmd   (cur_cmd),
    .rdata (cur_rd)
  );

  sbba_mem u_start_map (
    .clk   (clk),
    .cmd   (st_cmd),
    .rdata (st_rd)
  );

  // output register: load a finished result when the slot is free or draining
  assign res_take = res_valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp.status        <= res.status;
      rsp.block_out     <= res.block_out;
      rsp.free_now      <= res.free_now;
      rsp.free_at_start <= res.free_at_start;
      rsp.map_empty     <= res.map_empty;
      rsp.read_value    <= res.read_value;
      rsp.size_bytes    <= res.size_bytes;
    end
  end

  // no map write while the block sits idle waiting for a request
  `SBBA_ASSERT_NEVER(a_no_idle_write, clk, rst, req.ready && (cur_cmd.we || st_cmd.we))
  // the size in use never passes the map capacity
  `SBBA_ASSERT_IMP(a_size_cap, clk, rst, rsp.valid, rsp.size_bytes <= SIZE_W'(MAP_BYTES))
  // a taken request closes intake until its result is handed off
  `SBBA_ASSERT_NEXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready)

endmodule

// File: hw/rtl/sbba_mem.sv
// ----------------------------------------------------------------------------
// sbba_mem
// Byte-wide map memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbba_mem import sbba_pkg::*; (
  input  logic       clk,
  input  mem_cmd_t   cmd,
  output logic [7:0] rdata
);

  logic [7:0] mem [MAP_BYTES];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    rdata <= mem[cmd.raddr];
  end

endmodule

// File: hw/rtl/sbba_ctrl.sv
// ----------------------------------------------------------------------------
// sbba_ctrl
// Request sequencer: read-modify-write of both maps, scans and zero sweeps.
// ----------------------------------------------------------------------------
module sbba_ctrl import sbba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_fire,
  input  req_t              req_in,
  input  logic [STEP_W-1:0] step_cfg,
  output logic              ready,
  output mem_cmd_t          cur_cmd,
  output mem_cmd_t          st_cmd,
  input  logic [7:0]        cur_rd,
  input  logic [7:0]        st_rd,
  output logic              res_valid,
  output rsp_t              res,
  input  logic              res_take
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DISP  = 4'd1;
  localparam logic [3:0] ST_SWEEP = 4'd2;
  localparam logic [3:0] ST_FRD   = 4'd3;
  localparam logic [3:0] ST_A_RD  = 4'd4;
  localparam logic [3:0] ST_A_CHK = 4'd5;
  localparam logic [3:0] ST_L_RD  = 4'd6;
  localparam logic [3:0] ST_L_CHK = 4'd7;
  localparam logic [3:0] ST_PUSH  = 4'd8;

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAP_BYTES);

  logic [3:0]        state;
  logic [2:0]        op;
  logic [BLK_W-1:0]  blk_q;
  logic [11:0]       bidx_q;
  logic [7:0]        bval_q;
  logic [SIZE_W-1:0] obytes_q;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] hint;
  logic [SIZE_W-1:0] ptr;
  logic [SIZE_W-1:0] wptr;
  logic [SIZE_W-1:0] lim;
  logic [SIZE_W-1:0] scan_size;
  logic              ret_alloc;
  logic              sweep_both;
  logic [1:0]        res_status;
  logic [BLK_W-1:0]  res_block;
  logic              res_fnow;
  logic              res_fstart;
  logic              res_empty;
  logic [7:0]        res_rval;

  logic [11:0]       blk_byte;
  logic [7:0]        bit_mask;
  logic              blk_in;
  logic              bidx_in;
  logic [SIZE_W-1:0] step_eff;
  logic [SIZE_W:0]   grow_sum;
  logic [SIZE_W-1:0] open_size;
  logic [SIZE_W-1:0] ptr_m1;
  logic [7:0]        both_rd;
  logic [2:0]        lz;
  logic [2:0]        hb;
  logic [ADDR_W-1:0] rd_addr;

  assign blk_byte  = blk_q[BLK_W-1:3];
  assign bit_mask  = 8'b1 << blk_q[2:0];
  assign blk_in    = {1'b0, blk_byte} < size;
  assign bidx_in   = {1'b0, bidx_q} < size;
  assign step_eff  = (step_cfg == '0) ? SIZE_W'(1) : step_cfg;
  assign grow_sum  = {1'b0, scan_size} + {1'b0, step_eff};
  assign open_size = (obytes_q > SIZE_MAX) ? SIZE_MAX : obytes_q;
  assign ptr_m1    = ptr - SIZE_W'(1);
  assign both_rd   = cur_rd | st_rd;
  assign lz        = lowest_zero(both_rd);
  assign hb        = highest_one(cur_rd);

  assign ready     = (state == ST_IDLE);
  assign res_valid = (state == ST_PUSH);
  assign res = '{status: res_status, block_out: res_block, free_now: res_fnow,
                 free_at_start: res_fstart, map_empty: res_empty,
                 read_value: res_rval, size_bytes: size};

  // memory port drive
  always_comb begin
    cur_cmd = '0;
    st_cmd  = '0;
    rd_addr = '0;
    case (state)
      ST_DISP: begin
        case (op)
          REQ_LOAD: begin
            if (bidx_in) begin
              cur_cmd.we    = 1'b1;
              cur_cmd.waddr = bidx_q;
              cur_cmd.wdata = bval_q;
              st_cmd.we     = 1'b1;
              st_cmd.waddr  = bidx_q;
              st_cmd.wdata  = bval_q;
            end
          end
          REQ_FREE, REQ_QUERY: rd_addr = blk_byte;
          REQ_READ: rd_addr = bidx_q;
          default: ;
        endcase
      end
      ST_SWEEP: begin
        if (wptr != lim) begin
          cur_cmd.we    = 1'b1;
          cur_cmd.waddr = wptr[ADDR_W-1:0];
          st_cmd.we     = sweep_both;
          st_cmd.waddr  = wptr[ADDR_W-1:0];
        end
      end
      ST_FRD: begin
        if (op == REQ_FREE) begin
          cur_cmd.we    = 1'b1;
          cur_cmd.waddr = blk_byte;
          cur_cmd.wdata = cur_rd & ~bit_mask;
        end
      end
      ST_A_RD: rd_addr = ptr[ADDR_W-1:0];
      ST_A_CHK: begin
        if (both_rd != 8'hFF) begin
          cur_cmd.we    = 1'b1;
          cur_cmd.waddr = ptr[ADDR_W-1:0];
          cur_cmd.wdata = cur_rd | (8'b1 << lz);
        end
      end
      ST_L_RD: rd_addr = ptr_m1[ADDR_W-1:0];
      default: ;
    endcase
    cur_cmd.raddr = rd_addr;
    st_cmd.raddr  = rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      size  <= '0;
      hint  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            op       <= req_in.req_type;
            blk_q    <= req_in.block_id;
            bidx_q   <= req_in.byte_index;
            bval_q   <= req_in.byte_value;
            obytes_q <= req_in.open_bytes;
            state    <= ST_DISP;
          end
        end
        ST_DISP: begin
          res_status <= STAT_OK;
          res_block  <= '0;
          res_fnow   <= 1'b0;
          res_fstart <= 1'b0;
          res_empty  <= 1'b0;
          res_rval   <= '0;
          case (op)
            REQ_OPEN: begin
              size       <= open_size;
              hint       <= '0;
              wptr       <= '0;
              lim        <= open_size;
              sweep_both <= 1'b1;
              ret_alloc  <= 1'b0;
              state      <= ST_SWEEP;
            end
            REQ_LOAD: begin
              if (!bidx_in) res_status <= STAT_RANGE;
              state <= ST_PUSH;
            end
            REQ_ALLOC: begin
              ptr       <= hint;
              scan_size <= size;
              state     <= ST_A_RD;
            end
            REQ_FREE, REQ_QUERY: begin
              if (blk_in) begin
                state <= ST_FRD;
              end else begin
                res_status <= STAT_RANGE;
                state      <= ST_PUSH;
              end
            end
            REQ_LAST: begin
              ptr   <= size;
              state <= ST_L_RD;
            end
            REQ_CLEAR: begin
              wptr       <= '0;
              lim        <= size;
              sweep_both <= 1'b0;
              ret_alloc  <= 1'b0;
              state      <= ST_SWEEP;
            end
            default: begin
              if (bidx_in) begin
                state <= ST_FRD;
              end else begin
                res_status <= STAT_RANGE;
                state      <= ST_PUSH;
              end
            end
          endcase
        end
        ST_SWEEP: begin
          if (wptr == lim) begin
            state <= ret_alloc ? ST_A_RD : ST_PUSH;
          end else begin
            wptr <= wptr + SIZE_W'(1);
          end
        end
        ST_FRD: begin
          case (op)
            REQ_FREE: begin
              if (hint > {1'b0, blk_byte} && (st_rd & bit_mask) == '0) begin
                hint <= {1'b0, blk_byte};
              end
            end
            REQ_QUERY: begin
              res_fnow   <= (cur_rd & bit_mask) == '0;
              res_fstart <= (st_rd & bit_mask) == '0;
            end
            default: res_rval <= cur_rd;
          endcase
          state <= ST_PUSH;
        end
        ST_A_RD: begin
          if (ptr >= scan_size) begin
            if (grow_sum > (SIZE_W+1)'(MAP_BYTES)) begin
              res_status <= STAT_FULL;
              state      <= ST_PUSH;
            end else begin
              // zero the new bytes, then resume the scan
              wptr       <= scan_size;
              lim        <= grow_sum[SIZE_W-1:0];
              scan_size  <= grow_sum[SIZE_W-1:0];
              sweep_both <= 1'b1;
              ret_alloc  <= 1'b1;
              state      <= ST_SWEEP;
            end
          end else begin
            state <= ST_A_CHK;
          end
        end
        ST_A_CHK: begin
          if (both_rd != 8'hFF) begin
            hint      <= ptr;
            size      <= scan_size;
            res_block <= {ptr[ADDR_W-1:0], lz};
            state     <= ST_PUSH;
          end else begin
            ptr   <= ptr + SIZE_W'(1);
            state <= ST_A_RD;
          end
        end
        ST_L_RD: begin
          if (ptr == '0) begin
            res_empty <= 1'b1;
            state     <= ST_PUSH;
          end else begin
            state <= ST_L_CHK;
          end
        end
        ST_L_CHK: begin
          if (cur_rd != '0) begin
            size      <= ptr;
            res_block <= {ptr_m1[ADDR_W-1:0], hb};
            state     <= ST_PUSH;
          end else begin
            ptr   <= ptr_m1;
            state <= ST_L_RD;
          end
        end
        ST_PUSH: begin
          if (res_take) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: tb/shadowed_bitmap_block_allocator_top_test.sv
// ----------------------------------------------------------------------------
// shadowed_bitmap_block_allocator_top_test
// Drives request beats into the allocator and checks every result beat
// against a model of both bitmaps, the hint and the size in use. Runs
// several grow-step settings, most with random stalls on both channels.
// ----------------------------------------------------------------------------
module shadowed_bitmap_block_allocator_top_test;
  import sbba_pkg::*;

  localparam logic [1:0] GROW_STEP_ADDR = 2'd0;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PHASES = 6;

  // Bitmap allocator model plus the queue of results it still waits for.
  class alloc_scoreboard;
    logic [7:0] cur_map[MAP_BYTES];
    logic [7:0] snap_map[MAP_BYTES];
    int hint;
    int used;
    int step;
    rsp_t expected_rsps[$];
    int errors;

    function new();
      foreach (cur_map[k]) begin
        cur_map[k] = '0;
        snap_map[k] = '0;
      end
      hint = 0;
      used = 0;
      step = GROW_STEP_RESET;
      errors = 0;
    endfunction

    function int pending();
      return expected_rsps.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function logic [1:0] allocate(output int blk);
      int stp, old_size, sz, i, b, k;
      logic [7:0] x;
      stp = (step != 0) ? step : 1;
      old_size = used;
      sz = old_size;
      i = hint;
      x = '0;
      while (1) begin
        if (i >= sz) begin
          if (sz + stp > MAP_BYTES) begin
            blk = 0;
            return STAT_FULL;
          end
          sz += stp;
        end else begin
          x = (i >= old_size) ? 8'h00 : (snap_map[i] | cur_map[i]);
          if (x != 8'hFF) break;
          i++;
        end
      end
      // grown bytes read as zero in both maps, also below the hint
      for (k = old_size; k < sz; k++) begin
        cur_map[k] = '0;
        snap_map[k] = '0;
      end
      used = sz;
      b = 0;
      while (b < 7 && x[b]) b++;
      cur_map[i][b] = 1'b1;
      hint = i;
      blk = i * 8 + b;
      return STAT_OK;
    endfunction

    function rsp_t predict(req_t r);
      rsp_t e;
      int i, bitn, j, b, k, blk;
      e = '0;
      i = r.block_id >> 3;
      bitn = r.block_id[2:0];
      case (r.req_type)
        REQ_OPEN: begin
          foreach (cur_map[k2]) begin
            cur_map[k2] = '0;
            snap_map[k2] = '0;
          end
          hint = 0;
          used = (r.open_bytes > MAP_BYTES) ? MAP_BYTES : r.open_bytes;
        end
        REQ_LOAD: begin
          if (r.byte_index >= used) e.status = STAT_RANGE;
          else begin
            cur_map[r.byte_index] = r.byte_value;
            snap_map[r.byte_index] = r.byte_value;
          end
        end
        REQ_ALLOC: begin
          e.status = allocate(blk);
          e.block_out = blk[BLK_W-1:0];
        end
        REQ_FREE: begin
          if (i >= used) e.status = STAT_RANGE;
          else begin
            cur_map[i][bitn] = 1'b0;
            // only blocks free at transaction start pull the hint down
            if (hint > i && !snap_map[i][bitn]) hint = i;
          end
        end
        REQ_QUERY: begin
          if (i >= used) e.status = STAT_RANGE;
          else begin
            e.free_now = !cur_map[i][bitn];
            e.free_at_start = !snap_map[i][bitn];
          end
        end
        REQ_LAST: begin
          j = used;
          while (j > 0 && cur_map[j-1] == 8'h00) j--;
          if (j == 0) e.map_empty = 1'b1;
          else begin
            b = 7;
            while (b > 0 && !cur_map[j-1][b]) b--;
            used = j;
            e.block_out = BLK_W'((j - 1) * 8 + b);
          end
        end
        REQ_CLEAR: begin
          for (k = 0; k < used; k++) cur_map[k] = '0;
        end
        default: begin
          if (r.byte_index >= used) e.status = STAT_RANGE;
          else e.read_value = cur_map[r.byte_index];
        end
      endcase
      e.size_bytes = SIZE_W'(used);
      return e;
    endfunction

    function void note_request(req_t r);
      expected_rsps.push_back(predict(r));
    endfunction

    task check_result(rsp_t got);
      rsp_t e;
      if (expected_rsps.size() == 0) begin
        report("result beat with no request outstanding");
        return;
      end
      e = expected_rsps.pop_front();
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.block_out !== e.block_out)
        report($sformatf("block_out %0d, want %0d", got.block_out, e.block_out));
      if (got.free_now !== e.free_now)
        report($sformatf("free_now %0b, want %0b", got.free_now, e.free_now));
      if (got.free_at_start !== e.free_at_start)
        report($sformatf("free_at_start %0b, want %0b", got.free_at_start,
                         e.free_at_start));
      if (got.map_empty !== e.map_empty)
        report($sformatf("map_empty %0b, want %0b", got.map_empty, e.map_empty));
      if (got.read_value !== e.read_value)
        report($sformatf("read_value %0h, want %0h", got.read_value, e.read_value));
      if (got.size_bytes !== e.size_bytes)
        report($sformatf("size_bytes %0d, want %0d", got.size_bytes, e.size_bytes));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sbba_req_if req_ch ();
  sbba_rsp_if rsp_ch ();

  alloc_scoreboard sb = new();

  // Calm turns off random idling on both sides; hold_rsp asks the receiver
  // for one long hold-off.
  bit calm;
  bit hold_rsp;

  shadowed_bitmap_block_allocator_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch.sink),
    .rsp     (rsp_ch.source)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Hard stop: far beyond the slowest correct run of these sizes.
  initial begin
    #(12 * 4000000);
    $display("shadowed_bitmap_block_allocator_top test failed");
    $finish;
  end

  // Receiver: drop ready on about ten percent of cycles; on request, hold it low
  // for a long stretch so the block backs up and stalls its input.
  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        for (n = 0; n < 400; n++) @(posedge clk);
        hold_rsp = 1'b0;
      end
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // Watch both channels; state before this edge's updates is sampled here.
  always @(posedge clk) begin
    req_t r;
    rsp_t g;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        r.req_type   = req_ch.req_type;
        r.block_id   = req_ch.block_id;
        r.byte_index = req_ch.byte_index;
        r.byte_value = req_ch.byte_value;
        r.open_bytes = req_ch.open_bytes;
        sb.note_request(r);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        g.status        = rsp_ch.status;
        g.block_out     = rsp_ch.block_out;
        g.free_now      = rsp_ch.free_now;
        g.free_at_start = rsp_ch.free_at_start;
        g.map_empty     = rsp_ch.map_empty;
        g.read_value    = rsp_ch.read_value;
        g.size_bytes    = rsp_ch.size_bytes;
        sb.check_result(g);
      end
    end
  end

  // Offer one request beat and hold it until accepted; valid stays high
  // afterward so back-to-back beats need no toggle.
  task send_req(req_t r);
    int gap;
    if (!calm && $urandom_range(0, 99) < 10) begin
      gap = $urandom_range(1, 4);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.req_type;
    req_ch.block_id   <= r.block_id;
    req_ch.byte_index <= r.byte_index;
    req_ch.byte_value <= r.byte_value;
    req_ch.open_bytes <= r.open_bytes;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task send_op(logic [2:0] op, int blk, int idx, int val, int obytes);
    req_t r;
    r.req_type   = op;
    r.block_id   = BLK_W'(blk);
    r.byte_index = 12'(idx);
    r.byte_value = 8'(val);
    r.open_bytes = SIZE_W'(obytes);
    send_req(r);
  endtask

  // Drop valid and wait until every expected result has arrived.
  task drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task write_grow_step(int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GROW_STEP_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.step = value & 32'h1FFF;
  endtask

  // Mostly well-formed traffic on small maps; a few full-range fields so
  // every bit toggles and out-of-range paths are hit.
  function automatic req_t next_request();
    req_t r;
    int pick, wild;
    r.req_type   = REQ_READ;
    r.block_id   = BLK_W'($urandom);
    r.byte_index = 12'($urandom);
    r.byte_value = 8'($urandom);
    r.open_bytes = SIZE_W'($urandom);
    pick = $urandom_range(0, 99);
    wild = ($urandom_range(0, 99) < 6);
    if (pick < 7) begin
      r.req_type = REQ_OPEN;
      if (!wild) r.open_bytes = SIZE_W'($urandom_range(0, 48));
      else if ($urandom_range(0, 1) != 0) r.open_bytes = SIZE_W'(MAP_BYTES);
    end else if (pick < 27) begin
      r.req_type = REQ_LOAD;
      if (!wild && sb.used > 0) r.byte_index = 12'($urandom_range(0, sb.used - 1));
      if ($urandom_range(0, 3) == 0) r.byte_value = 8'hFF;
    end else if (pick < 53) begin
      r.req_type = REQ_ALLOC;
    end else if (pick < 68) begin
      r.req_type = REQ_FREE;
      if (!wild && sb.used > 0) r.block_id = BLK_W'($urandom_range(0, sb.used * 8 - 1));
    end else if (pick < 78) begin
      r.req_type = REQ_QUERY;
      if (!wild && sb.used > 0) r.block_id = BLK_W'($urandom_range(0, sb.used * 8 - 1));
    end else if (pick < 85) begin
      r.req_type = REQ_LAST;
    end else if (pick < 88) begin
      r.req_type = REQ_CLEAR;
    end else begin
      r.req_type = REQ_READ;
      if (!wild && sb.used > 0) r.byte_index = 12'($urandom_range(0, sb.used - 1));
    end
    return r;
  endfunction

  initial begin
    int steps[NUM_PHASES];
    int ph, n;
    steps = '{int'(GROW_STEP_RESET), 0, MAP_BYTES, 1, 5, 37};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_OPEN;
    req_ch.block_id = '0;
    req_ch.byte_index = '0;
    req_ch.byte_value = '0;
    req_ch.open_bytes = '0;
    calm = 1'b0;
    hold_rsp = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_grow_step(steps[ph]);
      @(posedge clk);
      calm = (ph == 4);

      if (ph == 0) begin
        // Zero size right after reset: everything is out of range except last
        // block, which reports an empty map, and allocate, which grows the map by one step.
        send_op(REQ_LOAD, 0, 0, 8'hA5, 0);
        send_op(REQ_READ, 0, 0, 0, 0);
        send_op(REQ_LAST, 0, 0, 0, 0);
        send_op(REQ_ALLOC, 0, 0, 0, 0);
        // Full-size map, extreme indexes and values.
        send_op(REQ_OPEN, 0, 0, 0, MAP_BYTES);
        send_op(REQ_LOAD, 0, 0, 8'hFF, 0);
        send_op(REQ_LOAD, 0, 4095, 8'h00, 0);
        send_op(REQ_READ, 0, 4095, 0, 0);
        send_op(REQ_READ, 0, 0, 0, 0);
        send_op(REQ_ALLOC, 0, 0, 0, 0);
        send_op(REQ_QUERY, 0, 0, 0, 0);
        send_op(REQ_FREE, 3, 0, 0, 0);
        send_op(REQ_QUERY, 32767, 0, 0, 0);
        send_op(REQ_FREE, 32767, 0, 0, 0);
        send_op(REQ_LAST, 0, 0, 0, 0);
        send_op(REQ_CLEAR, 0, 0, 0, 0);
        // Empty map on last block leaves the size alone.
        send_op(REQ_LAST, 0, 0, 0, 0);
        // Oversized open saturates; zero open gives an empty size.
        send_op(REQ_OPEN, 0, 0, 0, 8191);
        send_op(REQ_OPEN, 0, 0, 0, 0);
        send_op(REQ_OPEN, 0, 0, 0, 4);
        send_op(REQ_LOAD, 0, 3, 8'h80, 0);
        send_op(REQ_LAST, 0, 0, 0, 0);
      end
      if (ph == 2) begin
        // Step of a whole map on a used byte cannot grow: capacity full.
        send_op(REQ_OPEN, 0, 0, 0, 1);
        send_op(REQ_LOAD, 0, 0, 8'hFF, 0);
        send_op(REQ_ALLOC, 0, 0, 0, 0);
        send_op(REQ_ALLOC, 0, 0, 0, 0);
      end

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Long receiver hold-off while intake keeps offering beats.
        if (ph == 1 && n == 40) hold_rsp = 1'b1;
        // Sender pause until every result is back.
        if (ph == 3 && n == 120) drain();
        send_req(next_request());
      end
      drain();
      repeat (8) @(posedge clk);
    end

    calm = 1'b0;
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("shadowed_bitmap_block_allocator_top test passed");
    end else begin
      $display("shadowed_bitmap_block_allocator_top test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sbba_pkg.sv
hw/rtl/sbba_req_if.sv
hw/rtl/sbba_rsp_if.sv
hw/rtl/sbba_mem.sv
hw/rtl/sbba_ctrl.sv
hw/rtl/shadowed_bitmap_block_allocator_top.sv
tb/shadowed_bitmap_block_allocator_top_test.sv
